// ----- design/complex_arithmetic_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define CAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cau check failed");

// consequent holds in the cycle after the antecedent
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cau check failed");

`endif

// ----- design/cau_pkg.sv -----
package cau_pkg;

    // operation codes
    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_MOD = 3'd4
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    // control word that travels with every item
    typedef struct packed {
        logic valid;
        t_cmd cmd;
        logic neg_re;
        logic neg_im;
        logic dz;
    } t_ctl;

endpackage

// ----- design/complex_arithmetic_unit.sv -----
// complex arithmetic unit, signed fixed point with FRAC_BITS fraction bits
// input channel s_axis: tuser carries the operation (add, subtract, multiply,
//   divide, modulus of a), tdata the two complex operands
// output channel m_axis: tdata carries the complex result, tuser the status
//   (ok, division by zero, saturated)
// the pipeline has four front stages, DATA_WIDTH + 2 divide and square root
//   steps and one output register; throughput is one item per cycle unless
//   the receiver stalls; every operation runs the same pipeline, one quotient
//   bit per step stage after the first and one root bit per stage from the third
// reset clears every valid bit; the pipeline is empty afterwards and the
//   input is ready at once
// when the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis tready drops in the same cycle; nothing is lost or repeated
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // a_re, a_im, b_re, b_im
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    // cmd
    input  logic [2:0]                            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // res_re, res_im
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,
    // status
    output logic [1:0]                            o_m_axis_tuser
);
    localparam int W      = DATA_WIDTH;
    localparam int PW     = 2 * W;
    localparam int NST    = W + 2;
    localparam int OUT_DW = ((2 * W + 7) / 8) * 8;

    logic ce;
    assign ce              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    // chain between the step stages
    t_ctl           c_ctl    [NST+1];
    logic [PW-1:0]  c_mag_re [NST+1];
    logic [PW-1:0]  c_mag_im [NST+1];
    logic [PW-1:0]  c_nrm    [NST+1];
    logic [PW:0]    c_rem_re [NST+1];
    logic [PW:0]    c_rem_im [NST+1];
    logic [W:0]     c_q_re   [NST+1];
    logic [W:0]     c_q_im   [NST+1];
    logic           c_ovf_re [NST+1];
    logic           c_ovf_im [NST+1];
    logic [W-1:0]   c_root   [NST+1];
    logic [PW-1:0]  c_rsq    [NST+1];

    // decode, products and magnitudes
    cau_front #(.DATA_WIDTH(W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (i_s_axis_tvalid),
        .i_cmd    (i_s_axis_tuser),
        .i_a_re   (i_s_axis_tdata[W-1:0]),
        .i_a_im   (i_s_axis_tdata[2*W-1:W]),
        .i_b_re   (i_s_axis_tdata[3*W-1:2*W]),
        .i_b_im   (i_s_axis_tdata[4*W-1:3*W]),
        .o_ctl    (c_ctl[0]),
        .o_mag_re (c_mag_re[0]),
        .o_mag_im (c_mag_im[0]),
        .o_nrm    (c_nrm[0])
    );

    assign c_rem_re[0] = '0;
    assign c_rem_im[0] = '0;
    assign c_q_re[0]   = '0;
    assign c_q_im[0]   = '0;
    assign c_ovf_re[0] = 1'b0;
    assign c_ovf_im[0] = 1'b0;
    assign c_root[0]   = '0;
    assign c_rsq[0]    = '0;

    // divide and square root steps
    for (genvar k = 0; k < NST; k++) begin : g_iter
        cau_iter #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .STEP(k)) u_iter (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ce     (ce),
            .i_ctl    (c_ctl[k]),
            .i_mag_re (c_mag_re[k]),
            .i_mag_im (c_mag_im[k]),
            .i_nrm    (c_nrm[k]),
            .i_rem_re (c_rem_re[k]),
            .i_rem_im (c_rem_im[k]),
            .i_q_re   (c_q_re[k]),
            .i_q_im   (c_q_im[k]),
            .i_ovf_re (c_ovf_re[k]),
            .i_ovf_im (c_ovf_im[k]),
            .i_root   (c_root[k]),
            .i_rsq    (c_rsq[k]),
            .o_ctl    (c_ctl[k+1]),
            .o_mag_re (c_mag_re[k+1]),
            .o_mag_im (c_mag_im[k+1]),
            .o_nrm    (c_nrm[k+1]),
            .o_rem_re (c_rem_re[k+1]),
            .o_rem_im (c_rem_im[k+1]),
            .o_q_re   (c_q_re[k+1]),
            .o_q_im   (c_q_im[k+1]),
            .o_ovf_re (c_ovf_re[k+1]),
            .o_ovf_im (c_ovf_im[k+1]),
            .o_root   (c_root[k+1]),
            .o_rsq    (c_rsq[k+1])
        );
    end

    // result select, saturation and output register
    logic [W-1:0] res_re, res_im;
    t_status      status;

    cau_back #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_ctl    (c_ctl[NST]),
        .i_mag_re (c_mag_re[NST]),
        .i_mag_im (c_mag_im[NST]),
        .i_q_re   (c_q_re[NST]),
        .i_q_im   (c_q_im[NST]),
        .i_ovf_re (c_ovf_re[NST]),
        .i_ovf_im (c_ovf_im[NST]),
        .i_root   (c_root[NST]),
        .o_valid  (o_m_axis_tvalid),
        .o_res_re (res_re),
        .o_res_im (res_im),
        .o_status (status)
    );

    assign o_m_axis_tdata = OUT_DW'({res_im, res_re});
    assign o_m_axis_tuser = status;

endmodule

// ----- design/cau_front.sv -----
module cau_front import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  logic                           i_valid,
    input  logic [2:0]                     i_cmd,
    input  logic signed [DATA_WIDTH-1:0]   i_a_re,
    input  logic signed [DATA_WIDTH-1:0]   i_a_im,
    input  logic signed [DATA_WIDTH-1:0]   i_b_re,
    input  logic signed [DATA_WIDTH-1:0]   i_b_im,
    output t_ctl                           o_ctl,
    output logic [2*DATA_WIDTH-1:0]        o_mag_re,
    output logic [2*DATA_WIDTH-1:0]        o_mag_im,
    output logic [2*DATA_WIDTH-1:0]        o_nrm
);
    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = PW + 1;

    // stage 1: operand magnitudes, signs and add/sub sums
    t_ctl                r1_ctl, n1_ctl;
    logic [W-1:0]        r1_ar, r1_ai, r1_br, r1_bi;
    logic                r1_nar, r1_nai, r1_nbr, r1_nbi;
    logic signed [W:0]   r1_as_re, r1_as_im, n1_as_re, n1_as_im;

    always_comb begin
        n1_ctl        = '0;
        n1_ctl.valid  = i_valid;
        n1_ctl.cmd    = t_cmd'(i_cmd);
        if (t_cmd'(i_cmd) == CMD_SUB) begin
            n1_as_re = {i_a_re[W-1], i_a_re} - {i_b_re[W-1], i_b_re};
            n1_as_im = {i_a_im[W-1], i_a_im} - {i_b_im[W-1], i_b_im};
        end else begin
            n1_as_re = {i_a_re[W-1], i_a_re} + {i_b_re[W-1], i_b_re};
            n1_as_im = {i_a_im[W-1], i_a_im} + {i_b_im[W-1], i_b_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_ce) begin
            r1_ctl <= n1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_ar    <= i_a_re[W-1] ? -i_a_re : i_a_re;
            r1_ai    <= i_a_im[W-1] ? -i_a_im : i_a_im;
            r1_br    <= i_b_re[W-1] ? -i_b_re : i_b_re;
            r1_bi    <= i_b_im[W-1] ? -i_b_im : i_b_im;
            r1_nar   <= i_a_re[W-1];
            r1_nai   <= i_a_im[W-1];
            r1_nbr   <= i_b_re[W-1];
            r1_nbi   <= i_b_im[W-1];
            r1_as_re <= n1_as_re;
            r1_as_im <= n1_as_im;
        end
    end

    // stage 2: cross products and squares
    t_ctl                r2_ctl;
    logic [PW-1:0]       r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic                r2_s0, r2_s1, r2_s2, r2_s3;
    logic signed [W:0]   r2_as_re, r2_as_im;
    logic [W-1:0]        n2_x, n2_y;

    // modulus squares the first operand, divide the second
    always_comb begin
        n2_x = (r1_ctl.cmd == CMD_MOD) ? r1_ar : r1_br;
        n2_y = (r1_ctl.cmd == CMD_MOD) ? r1_ai : r1_bi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_ce) begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_p0    <= PW'(r1_ar) * PW'(r1_br);
            r2_p1    <= PW'(r1_ai) * PW'(r1_bi);
            r2_p2    <= PW'(r1_ar) * PW'(r1_bi);
            r2_p3    <= PW'(r1_ai) * PW'(r1_br);
            r2_p4    <= PW'(n2_x) * PW'(n2_x);
            r2_p5    <= PW'(n2_y) * PW'(n2_y);
            r2_s0    <= r1_nar ^ r1_nbr;
            r2_s1    <= r1_nai ^ r1_nbi;
            r2_s2    <= r1_nar ^ r1_nbi;
            r2_s3    <= r1_nai ^ r1_nbr;
            r2_as_re <= r1_as_re;
            r2_as_im <= r1_as_im;
        end
    end

    // stage 3: signed sums of products, norm
    t_ctl                r3_ctl;
    logic signed [SW-1:0] r3_sum_re, r3_sum_im, n3_sum_re, n3_sum_im;
    logic signed [SW-1:0] v0, v1, v2, v3;
    logic [PW-1:0]       r3_nrm;

    always_comb begin
        v0 = r2_s0 ? -$signed({1'b0, r2_p0}) : $signed({1'b0, r2_p0});
        v1 = r2_s1 ? -$signed({1'b0, r2_p1}) : $signed({1'b0, r2_p1});
        v2 = r2_s2 ? -$signed({1'b0, r2_p2}) : $signed({1'b0, r2_p2});
        v3 = r2_s3 ? -$signed({1'b0, r2_p3}) : $signed({1'b0, r2_p3});
        case (r2_ctl.cmd)
            CMD_MUL: begin
                n3_sum_re = v0 - v1;
                n3_sum_im = v2 + v3;
            end
            CMD_DIV: begin
                n3_sum_re = v0 + v1;
                n3_sum_im = v3 - v2;
            end
            default: begin
                n3_sum_re = SW'(r2_as_re);
                n3_sum_im = SW'(r2_as_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
        end else if (i_ce) begin
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_sum_re <= n3_sum_re;
            r3_sum_im <= n3_sum_im;
            r3_nrm    <= r2_p4 + r2_p5;
        end
    end

    // stage 4: sign and magnitude, zero divisor detect
    t_ctl                 r4_ctl, n4_ctl;
    logic [PW-1:0]        r4_mag_re, r4_mag_im, r4_nrm;
    logic signed [SW-1:0] n4_abs_re, n4_abs_im;

    always_comb begin
        n4_ctl        = r3_ctl;
        n4_ctl.neg_re = r3_sum_re[SW-1];
        n4_ctl.neg_im = r3_sum_im[SW-1];
        n4_ctl.dz     = (r3_ctl.cmd == CMD_DIV) && (r3_nrm == '0);
        n4_abs_re     = r3_sum_re[SW-1] ? -r3_sum_re : r3_sum_re;
        n4_abs_im     = r3_sum_im[SW-1] ? -r3_sum_im : r3_sum_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
        end else if (i_ce) begin
            r4_ctl <= n4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r4_mag_re <= n4_abs_re[PW-1:0];
            r4_mag_im <= n4_abs_im[PW-1:0];
            r4_nrm    <= r3_nrm;
        end
    end

    assign o_ctl    = r4_ctl;
    assign o_mag_re = r4_mag_re;
    assign o_mag_im = r4_mag_im;
    assign o_nrm    = r4_nrm;

endmodule

// ----- design/cau_iter.sv -----
module cau_iter import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int STEP       = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ce,
    input  t_ctl                      i_ctl,
    input  logic [2*DATA_WIDTH-1:0]   i_mag_re,
    input  logic [2*DATA_WIDTH-1:0]   i_mag_im,
    input  logic [2*DATA_WIDTH-1:0]   i_nrm,
    input  logic [2*DATA_WIDTH:0]     i_rem_re,
    input  logic [2*DATA_WIDTH:0]     i_rem_im,
    input  logic [DATA_WIDTH:0]       i_q_re,
    input  logic [DATA_WIDTH:0]       i_q_im,
    input  logic                      i_ovf_re,
    input  logic                      i_ovf_im,
    input  logic [DATA_WIDTH-1:0]     i_root,
    input  logic [2*DATA_WIDTH-1:0]   i_rsq,
    output t_ctl                      o_ctl,
    output logic [2*DATA_WIDTH-1:0]   o_mag_re,
    output logic [2*DATA_WIDTH-1:0]   o_mag_im,
    output logic [2*DATA_WIDTH-1:0]   o_nrm,
    output logic [2*DATA_WIDTH:0]     o_rem_re,
    output logic [2*DATA_WIDTH:0]     o_rem_im,
    output logic [DATA_WIDTH:0]       o_q_re,
    output logic [DATA_WIDTH:0]       o_q_im,
    output logic                      o_ovf_re,
    output logic                      o_ovf_im,
    output logic [DATA_WIDTH-1:0]     o_root,
    output logic [2*DATA_WIDTH-1:0]   o_rsq
);
    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int RW = PW + 1;
    localparam int NW = PW + FRAC_BITS;
    localparam int CW = PW + 2;

    t_ctl          r_ctl;
    logic [PW-1:0] r_mag_re, r_mag_im, r_nrm, r_rsq, n_rsq;
    logic [RW-1:0] r_rem_re, r_rem_im, n_rem_re, n_rem_im;
    logic [W:0]    r_q_re, r_q_im, n_q_re, n_q_im;
    logic          r_ovf_re, r_ovf_im, n_ovf_re, n_ovf_im;
    logic [W-1:0]  r_root, n_root;

    generate
        if (STEP == 0) begin : g_init
            // quotient would not fit: dividend high part already reaches the divisor
            logic [NW-1:0] hi_re, hi_im;
            always_comb begin
                hi_re    = {i_mag_re, {FRAC_BITS{1'b0}}} >> (W + 1);
                hi_im    = {i_mag_im, {FRAC_BITS{1'b0}}} >> (W + 1);
                n_ovf_re = hi_re >= NW'(i_nrm);
                n_ovf_im = hi_im >= NW'(i_nrm);
                n_rem_re = hi_re[RW-1:0];
                n_rem_im = hi_im[RW-1:0];
                n_q_re   = '0;
                n_q_im   = '0;
                n_root   = '0;
                n_rsq    = '0;
            end
        end else begin : g_step
            // one quotient bit per part
            localparam int QB = W + 1 - STEP;
            logic nb_re, nb_im;
            logic [RW-1:0] t_re, t_im;
            if (QB >= FRAC_BITS) begin : g_bit
                assign nb_re = i_mag_re[QB-FRAC_BITS];
                assign nb_im = i_mag_im[QB-FRAC_BITS];
            end else begin : g_zero
                assign nb_re = 1'b0;
                assign nb_im = 1'b0;
            end
            always_comb begin
                t_re     = {i_rem_re[RW-2:0], nb_re};
                t_im     = {i_rem_im[RW-2:0], nb_im};
                n_q_re   = i_q_re;
                n_q_im   = i_q_im;
                n_rem_re = t_re;
                n_rem_im = t_im;
                n_ovf_re = i_ovf_re;
                n_ovf_im = i_ovf_im;
                if (t_re >= RW'(i_nrm)) begin
                    n_rem_re   = t_re - RW'(i_nrm);
                    n_q_re[QB] = 1'b1;
                end
                if (t_im >= RW'(i_nrm)) begin
                    n_rem_im   = t_im - RW'(i_nrm);
                    n_q_im[QB] = 1'b1;
                end
            end
            // one root bit, tracking the square of the partial root
            if (STEP >= 2) begin : g_sqrt
                localparam int RB = W + 1 - STEP;
                logic [CW-1:0] csq;
                always_comb begin
                    csq    = CW'(i_rsq) + (CW'(i_root) << (RB + 1)) + (CW'(1) << (2 * RB));
                    n_root = i_root;
                    n_rsq  = i_rsq;
                    if (csq <= CW'(i_nrm)) begin
                        n_root = i_root | (W'(1) << RB);
                        n_rsq  = csq[PW-1:0];
                    end
                end
            end else begin : g_nosqrt
                assign n_root = i_root;
                assign n_rsq  = i_rsq;
            end
        end
    endgenerate

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_ce) begin
            r_ctl <= i_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_mag_re <= i_mag_re;
            r_mag_im <= i_mag_im;
            r_nrm    <= i_nrm;
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_q_re   <= n_q_re;
            r_q_im   <= n_q_im;
            r_ovf_re <= n_ovf_re;
            r_ovf_im <= n_ovf_im;
            r_root   <= n_root;
            r_rsq    <= n_rsq;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_mag_re = r_mag_re;
    assign o_mag_im = r_mag_im;
    assign o_nrm    = r_nrm;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;
    assign o_ovf_re = r_ovf_re;
    assign o_ovf_im = r_ovf_im;
    assign o_root   = r_root;
    assign o_rsq    = r_rsq;

endmodule

// ----- design/cau_back.sv -----
module cau_back import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  t_ctl                          i_ctl,
    input  logic [2*DATA_WIDTH-1:0]       i_mag_re,
    input  logic [2*DATA_WIDTH-1:0]       i_mag_im,
    input  logic [DATA_WIDTH:0]           i_q_re,
    input  logic [DATA_WIDTH:0]           i_q_im,
    input  logic                          i_ovf_re,
    input  logic                          i_ovf_im,
    input  logic [DATA_WIDTH-1:0]         i_root,
    output logic                          o_valid,
    output logic [DATA_WIDTH-1:0]         o_res_re,
    output logic [DATA_WIDTH-1:0]         o_res_im,
    output t_status                       o_status
);
    localparam int W  = DATA_WIDTH;
    localparam int MW = 2 * W + 1;
    localparam logic [MW-1:0] MAX_POS = MW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [MW-1:0] MAX_NEG = MW'(64'd1 << (W - 1));

    logic [MW-1:0] m_re, m_im;
    logic          s_re, s_im, sat_re, sat_im;
    logic [W-1:0]  n_res_re, n_res_im;
    t_status       n_status;
    logic          r_valid;
    logic [W-1:0]  r_res_re, r_res_im;
    t_status       r_status;

    // pick magnitude and sign per operation
    always_comb begin
        m_re = '0;
        m_im = '0;
        s_re = 1'b0;
        s_im = 1'b0;
        case (i_ctl.cmd)
            CMD_ADD, CMD_SUB: begin
                m_re = MW'(i_mag_re);
                m_im = MW'(i_mag_im);
                s_re = i_ctl.neg_re;
                s_im = i_ctl.neg_im;
            end
            CMD_MUL: begin
                m_re = MW'(i_mag_re >> FRAC_BITS);
                m_im = MW'(i_mag_im >> FRAC_BITS);
                s_re = i_ctl.neg_re;
                s_im = i_ctl.neg_im;
            end
            CMD_DIV: begin
                if (!i_ctl.dz) begin
                    m_re = i_ovf_re ? '1 : MW'(i_q_re);
                    m_im = i_ovf_im ? '1 : MW'(i_q_im);
                    s_re = i_ctl.neg_re;
                    s_im = i_ctl.neg_im;
                end
            end
            CMD_MOD: begin
                m_re = MW'(i_root);
            end
            default: begin
                m_re = '0;
            end
        endcase
    end

    // saturate to the word range
    always_comb begin
        sat_re = s_re ? (m_re > MAX_NEG) : (m_re > MAX_POS);
        sat_im = s_im ? (m_im > MAX_NEG) : (m_im > MAX_POS);
        if (sat_re) begin
            n_res_re = s_re ? MAX_NEG[W-1:0] : MAX_POS[W-1:0];
        end else begin
            n_res_re = s_re ? -m_re[W-1:0] : m_re[W-1:0];
        end
        if (sat_im) begin
            n_res_im = s_im ? MAX_NEG[W-1:0] : MAX_POS[W-1:0];
        end else begin
            n_res_im = s_im ? -m_im[W-1:0] : m_im[W-1:0];
        end
        if (i_ctl.cmd == CMD_DIV && i_ctl.dz) begin
            n_status = ST_DIV_ZERO;
        end else if (sat_re || sat_im) begin
            n_status = ST_SAT;
        end else begin
            n_status = ST_OK;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;

endmodule

// ----- design/cau_checker.sv -----
`include "complex_arithmetic_unit_assert.svh"

module cau_checker import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic [((4*DATA_WIDTH+7)/8)*8-1:0]     i_s_axis_tdata,
    input logic [2:0]                            i_s_axis_tuser,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [((2*DATA_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,
    input logic [1:0]                            o_m_axis_tuser
);
    localparam int OUT_DW = ((2 * DATA_WIDTH + 7) / 8) * 8;

    logic              out_stall;
    logic              status_known;
    logic              dz_out;
    logic [OUT_DW+1:0] out_item;

    // helper terms for the checks below
    assign out_stall    = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_item     = {o_m_axis_tuser, o_m_axis_tdata};
    assign status_known = (o_m_axis_tuser == ST_OK) || (o_m_axis_tuser == ST_DIV_ZERO) ||
                          (o_m_axis_tuser == ST_SAT);
    assign dz_out       = o_m_axis_tvalid && (o_m_axis_tuser == ST_DIV_ZERO);

    // a stalled result holds still
    `CAU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_stall, o_m_axis_tvalid && $stable(out_item))
    // an empty output slot always lets the pipeline advance
    `CAU_ASSERT_NOW(a_ready, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)
    // only defined status codes leave the block
    `CAU_ASSERT_NOW(a_status, i_clk, i_rst_n, o_m_axis_tvalid, status_known)
    // a zero divisor gives a zero result
    `CAU_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, dz_out, o_m_axis_tdata == '0)

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

// ----- tb/complex_arithmetic_unit_tb.sv -----
module complex_arithmetic_unit_tb;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int LATENCY    = DATA_WIDTH + 7;
    localparam int N_RANDOM   = 1000;
    localparam logic [31:0] MAX_W = 32'h7fff_ffff;
    localparam logic [31:0] MIN_W = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        t_status     st;
    } t_cres;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] ar, ai, br, bi;
        logic        known;
        t_cres       res;
    } t_vec;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;
    logic [2:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [63:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    t_cres pending_results[$];
    int    error_count;
    bit    hold_request;

    complex_arithmetic_unit #(.FRAC_BITS(FRAC_BITS), .DATA_WIDTH(DATA_WIDTH)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("complex_arithmetic_unit: mismatch");
        $finish;
    end

    // clamp a wide signed value into the word range
    function automatic logic [31:0] clamp_word(input logic signed [127:0] v, inout bit sat);
        if (v > $signed({96'd0, MAX_W})) begin
            sat = 1'b1;
            return MAX_W;
        end
        if (v < -$signed(129'sh8000_0000)) begin
            sat = 1'b1;
            return MIN_W;
        end
        return v[31:0];
    endfunction

    // truncating division of signed by positive, toward zero
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic signed [127:0] q;
        q = (n < 0) ? -((-n) / d) : n / d;
        return q;
    endfunction

    // exact complex arithmetic with saturation
    function automatic t_cres complex_result(input logic [2:0] cmd,
                                             input logic [31:0] ar_w, ai_w, br_w, bi_w);
        logic signed [127:0] ar, ai, br, bi, re, im, den, sq;
        logic [63:0] root, cand;
        bit sat;
        t_cres r;
        ar = 128'($signed(ar_w)); ai = 128'($signed(ai_w));
        br = 128'($signed(br_w)); bi = 128'($signed(bi_w));
        re = 0; im = 0; sat = 1'b0;
        r.st = ST_OK;
        case (cmd)
            CMD_ADD: begin
                re = ar + br; im = ai + bi;
            end
            CMD_SUB: begin
                re = ar - br; im = ai - bi;
            end
            CMD_MUL: begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
                re = (re < 0) ? -((-re) >>> FRAC_BITS) : re >>> FRAC_BITS;
                im = (im < 0) ? -((-im) >>> FRAC_BITS) : im >>> FRAC_BITS;
            end
            CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.st = ST_DIV_ZERO;
                end else begin
                    re = div_trunc((ar * br + ai * bi) <<< FRAC_BITS, den);
                    im = div_trunc((ai * br - ar * bi) <<< FRAC_BITS, den);
                end
            end
            CMD_MOD: begin
                sq = ar * ar + ai * ai;
                root = 64'd0;
                for (int b = 63; b >= 0; b--) begin
                    cand = root | (64'd1 << b);
                    if ($signed({64'd0, cand}) * $signed({64'd0, cand}) <= sq) root = cand;
                end
                re = $signed({64'd0, root});
            end
            default: ;
        endcase
        r.re = clamp_word(re, sat);
        r.im = clamp_word(im, sat);
        if (r.st == ST_OK && sat) r.st = ST_SAT;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return MAX_W;
            1: return MIN_W;
            2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'd0;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            4: return 32'($signed(16'($urandom))) << 8;
            default: return $urandom;
        endcase
    endfunction

    // hand one item to the block and record its expected result
    task automatic send_item(input t_vec v);
        t_cres exp_res;
        exp_res = complex_result(v.cmd, v.ar, v.ai, v.br, v.bi);
        if (v.known && exp_res !== v.res) begin
            $display("%0t: table row disagrees: expected %h, predicted %h", $time, v.res, exp_res);
            error_count++;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= v.cmd;
        i_s_axis_tdata  <= {v.bi, v.br, v.ai, v.ar};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results.push_back(exp_res);
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stimulus
    initial begin
        t_vec directed[$];
        t_vec v;
        int wait_cycles;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        error_count = 0;
        hold_request = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cmd, ar, ai, br, bi, known, {re, im, status}
        directed.push_back('{CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1, '{0, 0, ST_OK}});
        directed.push_back('{CMD_ADD, MAX_W, MAX_W, 32'd1, 32'd1, 1, '{MAX_W, MAX_W, ST_SAT}});
        directed.push_back('{CMD_ADD, MIN_W, MIN_W, MIN_W, 32'd0, 1, '{MIN_W, MIN_W, ST_SAT}});
        directed.push_back('{CMD_SUB, MIN_W, 32'd5, 32'd1, 32'd2, 1, '{MIN_W, 32'd3, ST_SAT}});
        directed.push_back('{CMD_SUB, 32'd0, MAX_W, MIN_W, MIN_W, 1, '{MAX_W, MAX_W, ST_SAT}});
        directed.push_back('{CMD_SUB, 32'd7, 32'd9, 32'd3, 32'd4, 1, '{32'd4, 32'd5, ST_OK}});
        directed.push_back('{CMD_MUL, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 1,
                             '{-32'sh5_0000, 32'hA_0000, ST_OK}});
        directed.push_back('{CMD_MUL, MAX_W, MAX_W, MAX_W, MIN_W, 0, '0});
        directed.push_back('{CMD_MUL, MIN_W, MIN_W, MIN_W, MIN_W, 0, '0});
        directed.push_back('{CMD_MUL, -32'sd1, 32'd1, 32'd1, 32'd0, 0, '0});
        directed.push_back('{CMD_DIV, 32'd5, 32'd6, 32'd0, 32'd0, 1, '{0, 0, ST_DIV_ZERO}});
        directed.push_back('{CMD_DIV, MAX_W, MIN_W, 32'd0, 32'd0, 1, '{0, 0, ST_DIV_ZERO}});
        directed.push_back('{CMD_DIV, MAX_W, MAX_W, 32'd1, 32'd0, 1, '{MAX_W, MAX_W, ST_SAT}});
        directed.push_back('{CMD_DIV, MIN_W, MIN_W, MIN_W, MIN_W, 0, '0});
        directed.push_back('{CMD_DIV, -32'sd7, 32'd3, 32'h2_0000, 32'd0, 0, '0});
        directed.push_back('{CMD_DIV, 32'h1_0000, 32'd0, 32'h0_8000, -32'sh8000, 0, '0});
        directed.push_back('{CMD_MOD, 32'h3_0000, 32'h4_0000, 32'd9, 32'd9, 1,
                             '{32'h5_0000, 32'd0, ST_OK}});
        directed.push_back('{CMD_MOD, MIN_W, MIN_W, 32'd0, 32'd0, 1, '{MAX_W, 32'd0, ST_SAT}});
        directed.push_back('{CMD_MOD, MAX_W, 32'd0, 32'd0, 32'd0, 1, '{MAX_W, 32'd0, ST_OK}});
        directed.push_back('{CMD_MOD, 32'd0, 32'd0, 32'd0, 32'd0, 1, '{0, 0, ST_OK}});
        directed.push_back('{3'd5, 32'd1, 32'd2, 32'd3, 32'd4, 1, '{0, 0, ST_OK}});
        directed.push_back('{3'd6, MAX_W, MIN_W, MAX_W, MIN_W, 1, '{0, 0, ST_OK}});
        directed.push_back('{3'd7, MIN_W, MAX_W, MIN_W, MAX_W, 1, '{0, 0, ST_OK}});
        foreach (directed[i]) begin
            send_item(directed[i]);
            sender_gap();
        end

        // receiver hold-off while the sender keeps the block full
        hold_request <= 1'b1;
        for (int i = 0; i < 3 * LATENCY; i++) begin
            v.cmd = 3'($urandom_range(0, 4));
            v.ar = rand_operand(); v.ai = rand_operand();
            v.br = rand_operand(); v.bi = rand_operand();
            v.known = 1'b0; v.res = '0;
            send_item(v);
        end
        hold_request <= 1'b0;

        for (int i = 0; i < N_RANDOM; i++) begin
            v.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
            v.ar = rand_operand(); v.ai = rand_operand();
            v.br = rand_operand(); v.bi = rand_operand();
            if (v.cmd == CMD_DIV && $urandom_range(0, 15) == 0) begin
                v.br = 32'd0; v.bi = 32'd0;
            end
            v.known = 1'b0; v.res = '0;
            send_item(v);
            if (i == N_RANDOM / 2) begin
                // drain completely before going on
                i_s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end else if (i % 150 < 120) begin
                sender_gap();
            end
        end
        i_s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("complex_arithmetic_unit: match");
        end else begin
            $display("complex_arithmetic_unit: mismatch");
        end
        $finish;
    end

    // result side back pressure
    initial begin
        int n;
        i_m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_m_axis_tready <= 1'b0;
                n = 0;
                while (n < 4 * LATENCY) begin
                    @(posedge i_clk);
                    n++;
                end
                i_m_axis_tready <= 1'b1;
                do @(posedge i_clk); while (hold_request);
            end else if ($urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_cres exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: actual %h %h %0d",
                         $time, o_m_axis_tdata[31:0], o_m_axis_tdata[63:32], o_m_axis_tuser);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_res.re) begin
                    $display("%0t: res_re expected %h actual %h",
                             $time, exp_res.re, o_m_axis_tdata[31:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[63:32] !== exp_res.im) begin
                    $display("%0t: res_im expected %h actual %h",
                             $time, exp_res.im, o_m_axis_tdata[63:32]);
                    error_count++;
                end
                if (o_m_axis_tuser !== exp_res.st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.st, o_m_axis_tuser);
                    error_count++;
                end
            end
        end
    end
endmodule
